### design/ncv_pkg.sv
// ----------------------------------------------------------------------------
// ncv_pkg
// Types, character codes and helper functions for the NMEA checksum verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ncv_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SUM  = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] HEX_ALPHA_BASE_UC = 8'h37;  // 'A' - 10
  localparam logic [7:0] HEX_ALPHA_BASE_LC = 8'h57;  // 'a' - 10

  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic       mismatch;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_nibble_t;

  function automatic logic is_terminator(input logic [7:0] c);
    return (c == CHAR_NUL) || (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_SPACE);
  endfunction

  function automatic hex_nibble_t hex_digit(input logic [7:0] c);
    hex_nibble_t h;
    logic [7:0]  diff;
    h    = '0;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff    = c - CHAR_ZERO;
      h.valid = 1'b1;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      diff    = c - HEX_ALPHA_BASE_UC;
      h.valid = 1'b1;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      diff    = c - HEX_ALPHA_BASE_LC;
      h.valid = 1'b1;
    end
    h.value = diff[3:0];
    return h;
  endfunction

endpackage

`default_nettype wire

### design/ncv_sentence_fsm.sv
// ----------------------------------------------------------------------------
// ncv_sentence_fsm
// Sentence phase tracking, running XOR, hex parsing and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ncv_sentence_fsm
  import ncv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] char_byte,
  input  wire logic       sentence_start,
  output logic            result_valid,
  output result_t         result
);

  phase_t      phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  parsed_value, parsed_value_next;
  logic        value_overflow, value_overflow_next;
  hex_nibble_t nib;

  assign nib = hex_digit(char_byte);

  // next state
  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    parsed_value_next   = parsed_value;
    value_overflow_next = value_overflow;
    if (step) begin
      if (sentence_start) begin
        // drop any open sentence and skip the start byte
        phase_next          = PH_SUM;
        running_xor_next    = '0;
        parsed_value_next   = '0;
        value_overflow_next = 1'b0;
      end else begin
        unique case (phase)
          PH_SUM: begin
            if (char_byte == CHAR_STAR) begin
              phase_next = PH_HEX;
            end else begin
              running_xor_next = running_xor ^ char_byte;
            end
          end
          PH_HEX: begin
            if (is_terminator(char_byte)) begin
              phase_next = PH_IDLE;
            end else if (nib.valid) begin
              if (parsed_value[7:4] != 4'h0) begin
                value_overflow_next = 1'b1;
              end
              parsed_value_next = {parsed_value[3:0], nib.value};
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    result_valid        = step && !sentence_start && (phase == PH_HEX) &&
                          is_terminator(char_byte);
    result.mismatch     = value_overflow || (parsed_value != running_xor);
    result.computed_sum = running_xor;
    result.received_sum = parsed_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      running_xor    <= '0;
      parsed_value   <= '0;
      value_overflow <= 1'b0;
    end else begin
      phase          <= phase_next;
      running_xor    <= running_xor_next;
      parsed_value   <= parsed_value_next;
      value_overflow <= value_overflow_next;
    end
  end

endmodule

`default_nettype wire

### design/ncv_result_reg.sv
// ----------------------------------------------------------------------------
// ncv_result_reg
// Output register holding one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ncv_result_reg
  import ncv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire result_t in_result,
  output logic         load_ok,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic out_valid_next;

  // free when empty or when the held word leaves this cycle
  assign load_ok        = !out_valid || out_ready;
  assign out_valid_next = load_ok ? in_valid : out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && in_valid) begin
      out_result <= in_result;
    end
  end

endmodule

`default_nettype wire

### design/nmea_checksum_verifier_unit.sv
// ----------------------------------------------------------------------------
// nmea_checksum_verifier_unit
// Streaming checker for the XOR checksum of NMEA 0183 style sentences.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle on the slave stream; s_tuser marks the first byte
// of a sentence, which is skipped and clears all sums. Bytes up to '*' are
// XORed, hex digits after '*' form the received checksum (non-hex bytes are
// ignored), and a NUL, CR, LF or space then emits one result word with the
// mismatch flag and both checksums. Each byte is handled by the sentence state
// logic and lands in a one-deep output register, so the block sustains one
// byte per clock; s_tready drops only while a finished result is held and
// m_tready is low. A result appears on m_tvalid the cycle after its
// terminator byte is accepted.
`default_nettype none

module nmea_checksum_verifier_unit
  import ncv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] char_byte
  input  wire logic [0:0]  s_tuser,  // [0] sentence_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // [0] mismatch, [8:1] computed_sum,
                                     // [16:9] received_sum, [23:17] zero
);

  logic    step;
  logic    res_valid;
  result_t res;
  result_t held;
  logic    load_ok;

  assign s_tready = load_ok;
  assign step     = s_tvalid && load_ok;

  ncv_sentence_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .char_byte      (s_tdata),
    .sentence_start (s_tuser[0]),
    .result_valid   (res_valid),
    .result         (res)
  );

  ncv_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (res_valid),
    .in_result  (res),
    .load_ok    (load_ok),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (held)
  );

  assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, held};

endmodule

`default_nettype wire

### design/ncv_checker.sv
// ----------------------------------------------------------------------------
// ncv_checker
// Port-level checks for the NMEA checksum verifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncv_checker
  import ncv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // input side is never blocked with an empty output register
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // differing sums must be flagged
  a_mismatch_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[8:1] != m_tdata[16:9]) |-> m_tdata[0])
    else $error("sums differ but mismatch is clear");

  // a new result follows an accepted terminator byte
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |->
      $past(s_tvalid && s_tready && !s_tuser[0] &&
            (s_tdata == CHAR_NUL || s_tdata == CHAR_CR ||
             s_tdata == CHAR_LF || s_tdata == CHAR_SPACE)))
    else $error("result without an accepted terminator");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:17] == 7'd0)
    else $error("result padding bits not zero");

endmodule

bind nmea_checksum_verifier_unit ncv_checker u_ncv_checker (.*);

`default_nettype wire
